FILE: hdl/pdlz_pkg.sv
// Shared types, constants and token codes for the PalmDoc LZ77 decompressor.
package pdlz_pkg;

  // Default sizing for the top level parameters
  localparam int LENGTH_BITS_DEF   = 3;
  localparam int HISTORY_DEPTH_DEF = 2048;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 16;
  localparam int LIT_W   = 4;
  localparam int HIGH_W  = 6;
  localparam int WORD_W  = HIGH_W + BYTE_W;

  // Byte classes and constants of the format
  localparam logic [BYTE_W-1:0] LIT_RUN_MIN = 8'h01;
  localparam logic [BYTE_W-1:0] LIT_RUN_MAX = 8'h08;
  localparam logic [BYTE_W-1:0] PAIR_BASE   = 8'h80;
  localparam logic [BYTE_W-1:0] SPACE_BASE  = 8'hC0;
  localparam logic [BYTE_W-1:0] TOP_FLIP    = 8'h80;
  localparam logic [BYTE_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [HIGH_W-1:0] HIGH_MASK   = 6'h3F;
  localparam int                MIN_COPY    = 3;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 16'hFFFF;
  localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'h8000;

  // Token actions from the decoder
  localparam logic [2:0] ACT_NONE  = 3'd0;  // count byte or first byte of a pair
  localparam logic [2:0] ACT_ONE   = 3'd1;  // one literal byte
  localparam logic [2:0] ACT_OVER  = 3'd2;  // token dropped past the limit
  localparam logic [2:0] ACT_SPACE = 3'd3;  // space plus one character
  localparam logic [2:0] ACT_COPY  = 3'd4;  // second byte of a copy pair

  typedef struct packed {
    logic [2:0]        act;
    logic [BYTE_W-1:0] first;
    logic [WORD_W-1:0] word;
    logic [LIT_W-1:0]  lit_next;
    logic              pair_next;
    logic [HIGH_W-1:0] high_next;
  } dec_t;

endpackage

FILE: hdl/pdlz_if.sv
// Valid/ready stream interfaces for compressed input and decompressed output items.
interface pdlz_in_if;
  logic                          valid;
  logic                          ready;
  logic [pdlz_pkg::BYTE_W-1:0]   in_byte;
  logic                          in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pdlz_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdlz_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_last;
  logic                          bad_distance;
  logic                          over_limit;

  modport source (output valid, output out_byte, output out_last,
                  output bad_distance, output over_limit, input ready);
  modport sink (input valid, input out_byte, input out_last,
                input bad_distance, input over_limit, output ready);
endinterface

FILE: hdl/pdlz_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdlz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pdlz_decode.sv
// Token decoder: classifies one compressed byte against the parser state.
module pdlz_decode (
  input  logic [pdlz_pkg::BYTE_W-1:0] in_byte,
  input  logic [pdlz_pkg::LIT_W-1:0]  lit_left,
  input  logic                        pair_pending,
  input  logic [pdlz_pkg::HIGH_W-1:0] pair_high,
  input  logic                        blocked,
  output pdlz_pkg::dec_t              dec
);

  always_comb begin
    dec.act       = pdlz_pkg::ACT_NONE;
    dec.first     = in_byte;
    dec.word      = {pair_high, in_byte};
    dec.lit_next  = lit_left;
    dec.pair_next = 1'b0;
    dec.high_next = '0;

    if (pair_pending) begin
      // Second byte of a copy pair
      dec.act = blocked ? pdlz_pkg::ACT_OVER : pdlz_pkg::ACT_COPY;
    end else if (lit_left != '0) begin
      // Raw literal inside a counted run
      dec.lit_next = lit_left - 1'b1;
      dec.act      = blocked ? pdlz_pkg::ACT_OVER : pdlz_pkg::ACT_ONE;
    end else if (in_byte >= pdlz_pkg::LIT_RUN_MIN && in_byte <= pdlz_pkg::LIT_RUN_MAX) begin
      // Announce a run of raw literals
      dec.lit_next = in_byte[pdlz_pkg::LIT_W-1:0];
    end else if (in_byte < pdlz_pkg::PAIR_BASE) begin
      dec.act = blocked ? pdlz_pkg::ACT_OVER : pdlz_pkg::ACT_ONE;
    end else if (in_byte >= pdlz_pkg::SPACE_BASE) begin
      dec.act   = blocked ? pdlz_pkg::ACT_OVER : pdlz_pkg::ACT_SPACE;
      dec.first = in_byte ^ pdlz_pkg::TOP_FLIP;
    end else begin
      // First byte of a copy pair: keep its low bits
      dec.pair_next = 1'b1;
      dec.high_next = in_byte[pdlz_pkg::HIGH_W-1:0] & pdlz_pkg::HIGH_MASK;
    end
  end

endmodule

FILE: hdl/palmdoc_lz77_decompressor.sv
// PalmDoc LZ77 decompressor top level: token sequencer around the history RAM.
//
// Takes one compressed byte per item and gives the decompressed bytes it
// completes, one result item per cycle at most. A literal or a dropped token
// gives one result and a space token two (a space, then the character). A
// good copy of length L is accepted, read from the history RAM, then given one
// byte per cycle while the output does not stall, with a forwarding path for
// overlapping copies; a copy with a bad distance gives L flagged results.
// Count bytes and the first byte of a pair give no result. A stalled output
// holds the token in progress, and no new byte is taken until it is done.
// The single write port of the history RAM, one byte per unstalled cycle, sets the
// copy rate. The history RAM needs no clearing after reset: a valid copy only
// reads bytes written earlier in the same record.
module palmdoc_lz77_decompressor #(
  parameter int LENGTH_BITS   = pdlz_pkg::LENGTH_BITS_DEF,
  parameter int HISTORY_DEPTH = pdlz_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [pdlz_pkg::CNT_W-1:0] cfg_wdata,
  pdlz_in_if.sink                    in_stream,
  pdlz_out_if.source                 out_stream
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int DIST_W = pdlz_pkg::WORD_W - LENGTH_BITS;
  localparam int LEN_W  = $clog2((1 << LENGTH_BITS) + pdlz_pkg::MIN_COPY);
  localparam int SUM_W  = ((AW > DIST_W) ? AW : DIST_W) + 2;
  localparam int BW     = pdlz_pkg::BYTE_W;
  localparam int CW     = pdlz_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SPACE2 = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_COPY   = 2'd3;

  logic [1:0]                  state, state_next;
  logic [pdlz_pkg::LIT_W-1:0]  lit_left, lit_left_next;
  logic                        pair_pending, pair_pending_next;
  logic [pdlz_pkg::HIGH_W-1:0] pair_high, pair_high_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               limit;
  logic [AW-1:0]               wp, wp_next, wp_inc;
  logic [AW-1:0]               src, src_next, src_inc, src_start;
  logic [LEN_W-1:0]            rd_left, rd_left_next, em_left, em_left_next;
  logic                        qv, qv_next;
  logic                        last_flag, last_flag_next;
  logic [BW-1:0]               hold_byte, hold_byte_next;

  logic                        o_valid, o_last, o_bad, o_over;
  logic [BW-1:0]               o_byte;

  logic                        fwd_hit;
  logic [BW-1:0]               fwd_data;
  logic [BW-1:0]               ram_q, copy_byte;

  logic                        advance, blocked, in_fire;
  logic                        emit, e_last, e_bad, e_over, end_rec, issue, we;
  logic [BW-1:0]               e_byte;
  pdlz_pkg::dec_t              dec;
  logic [DIST_W-1:0]           copy_dist;
  logic [LEN_W-1:0]            len;
  logic                        dist_bad;
  logic [SUM_W-1:0]            src_sum, src_wrap;

  // Token classification
  pdlz_decode u_decode (
    .in_byte      (in_stream.in_byte),
    .lit_left     (lit_left),
    .pair_pending (pair_pending),
    .pair_high    (pair_high),
    .blocked      (blocked),
    .dec          (dec)
  );

  // History memory
  pdlz_ram #(
    .WIDTH (BW),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (e_byte),
    .re    (issue),
    .raddr (src),
    .rdata (ram_q)
  );

  // Handshake and copy arithmetic
  assign advance   = !o_valid || out_stream.ready;
  assign blocked   = count >= limit;
  assign in_stream.ready = (state == ST_IDLE) && advance;
  assign in_fire   = in_stream.valid && in_stream.ready;

  assign copy_dist = dec.word[pdlz_pkg::WORD_W-1:LENGTH_BITS];
  assign len       = LEN_W'(dec.word[LENGTH_BITS-1:0]) + LEN_W'(pdlz_pkg::MIN_COPY);
  assign dist_bad  = (copy_dist == '0) || (CW'(copy_dist) > count) ||
                     (SUM_W'(copy_dist) > SUM_W'(HISTORY_DEPTH));
  assign src_sum   = SUM_W'(wp) + SUM_W'(HISTORY_DEPTH) - SUM_W'(copy_dist);
  assign src_wrap  = (src_sum >= SUM_W'(HISTORY_DEPTH)) ?
                     (src_sum - SUM_W'(HISTORY_DEPTH)) : src_sum;
  assign src_start = src_wrap[AW-1:0];
  assign wp_inc    = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign src_inc   = (src == AW'(HISTORY_DEPTH - 1)) ? '0 : src + 1'b1;
  assign copy_byte = fwd_hit ? fwd_data : ram_q;
  assign we        = emit && !e_over;

  // Sequencer
  always_comb begin
    state_next        = state;
    lit_left_next     = lit_left;
    pair_pending_next = pair_pending;
    pair_high_next    = pair_high;
    count_next        = count;
    wp_next           = wp;
    src_next          = src;
    rd_left_next      = rd_left;
    em_left_next      = em_left;
    qv_next           = qv;
    last_flag_next    = last_flag;
    hold_byte_next    = hold_byte;
    emit              = 1'b0;
    e_byte            = '0;
    e_last            = 1'b0;
    e_bad             = 1'b0;
    e_over            = 1'b0;
    end_rec           = 1'b0;
    issue             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          lit_left_next     = in_stream.in_last ? '0 : dec.lit_next;
          pair_pending_next = in_stream.in_last ? 1'b0 : dec.pair_next;
          pair_high_next    = in_stream.in_last ? '0 : dec.high_next;
          last_flag_next    = in_stream.in_last;
          case (dec.act)
            pdlz_pkg::ACT_ONE: begin
              emit    = 1'b1;
              e_byte  = dec.first;
              e_last  = in_stream.in_last;
              end_rec = in_stream.in_last;
            end
            pdlz_pkg::ACT_OVER: begin
              emit    = 1'b1;
              e_over  = 1'b1;
              e_last  = in_stream.in_last;
              end_rec = in_stream.in_last;
            end
            pdlz_pkg::ACT_SPACE: begin
              emit           = 1'b1;
              e_byte         = pdlz_pkg::SPACE_CHAR;
              hold_byte_next = dec.first;
              state_next     = ST_SPACE2;
            end
            pdlz_pkg::ACT_COPY: begin
              em_left_next = len;
              if (dist_bad) begin
                state_next = ST_BAD;
              end else begin
                rd_left_next = len;
                src_next     = src_start;
                qv_next      = 1'b0;
                state_next   = ST_COPY;
              end
            end
            default: begin
              end_rec = in_stream.in_last;
            end
          endcase
        end
      end

      ST_SPACE2: begin
        if (advance) begin
          emit       = 1'b1;
          e_byte     = hold_byte;
          e_last     = last_flag;
          end_rec    = last_flag;
          state_next = ST_IDLE;
        end
      end

      ST_BAD: begin
        if (advance) begin
          emit         = 1'b1;
          e_bad        = 1'b1;
          em_left_next = em_left - 1'b1;
          if (em_left == LEN_W'(1)) begin
            e_last     = last_flag;
            end_rec    = last_flag;
            state_next = ST_IDLE;
          end
        end
      end

      ST_COPY: begin
        // Emit the byte the RAM returned, or the forwarded byte
        if (qv && advance) begin
          emit         = 1'b1;
          e_byte       = copy_byte;
          em_left_next = em_left - 1'b1;
          if (em_left == LEN_W'(1)) begin
            e_last     = last_flag;
            end_rec    = last_flag;
            state_next = ST_IDLE;
          end
        end
        // Issue the next history read
        if (rd_left != '0 && (!qv || advance)) begin
          issue        = 1'b1;
          src_next     = src_inc;
          rd_left_next = rd_left - 1'b1;
        end
        qv_next = issue ? 1'b1 : (emit ? 1'b0 : qv);
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Advance the write position and produced count; clear both at a record end
    if (we) begin
      wp_next    = wp_inc;
      count_next = (count == pdlz_pkg::COUNT_MAX) ? count : count + 1'b1;
    end
    if (end_rec) begin
      wp_next    = '0;
      count_next = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      lit_left     <= '0;
      pair_pending <= 1'b0;
      pair_high    <= '0;
      count        <= '0;
      wp           <= '0;
      qv           <= 1'b0;
      o_valid      <= 1'b0;
      fwd_hit      <= 1'b0;
      limit        <= pdlz_pkg::LIMIT_RESET;
    end else begin
      state        <= state_next;
      lit_left     <= lit_left_next;
      pair_pending <= pair_pending_next;
      pair_high    <= pair_high_next;
      count        <= count_next;
      wp           <= wp_next;
      qv           <= qv_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (out_stream.ready) begin
        o_valid <= 1'b0;
      end
      // Forward a byte written to the entry being read in the same cycle
      if (issue) begin
        fwd_hit <= we && (src == wp);
      end
      if (cfg_wen) begin
        limit <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src       <= src_next;
    rd_left   <= rd_left_next;
    em_left   <= em_left_next;
    last_flag <= last_flag_next;
    hold_byte <= hold_byte_next;
    if (issue) begin
      fwd_data <= e_byte;
    end
    if (emit) begin
      o_byte <= e_byte;
      o_last <= e_last;
      o_bad  <= e_bad;
      o_over <= e_over;
    end
  end

  assign out_stream.valid        = o_valid;
  assign out_stream.out_byte     = o_byte;
  assign out_stream.out_last     = o_last;
  assign out_stream.bad_distance = o_bad;
  assign out_stream.over_limit   = o_over;

`ifndef NO_ASSERTIONS
  // Read data pending only while a copy runs
  a_qv_in_copy: assert property (@(posedge clk) disable iff (rst)
    qv |-> (state == ST_COPY))
    else $error("history read pending outside a copy");

  // Every issued read is either pending or emitted
  a_copy_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (em_left == rd_left + LEN_W'(qv)))
    else $error("copy read and emit counts out of step");

  // A final byte with no result still ends the record
  a_silent_end: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_stream.in_last && dec.act == pdlz_pkg::ACT_NONE)
      |=> (count == '0 && wp == '0))
    else $error("record state not cleared after final byte");

  // Produced count only grows within a record
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    !end_rec |=> (count >= $past(count)))
    else $error("produced count went backward within a record");
`endif

endmodule

FILE: tb/sv/palmdoc_lz77_decompressor_tb.sv
// Testbench for the PalmDoc LZ77 decompressor: directed and random traffic checked by a predictor.
`timescale 1ns / 1ps

// Decodes accepted compressed bytes into expected output items and checks the DUT's results
class decomp_scoreboard;
  typedef struct packed {
    logic [pdlz_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic                        bad;
    logic                        over;
  } out_item_t;

  logic [pdlz_pkg::BYTE_W-1:0] history [pdlz_pkg::HISTORY_DEPTH_DEF];
  int unsigned                 literals_left;
  bit                          pair_pending;
  logic [pdlz_pkg::HIGH_W-1:0] pair_high;
  int unsigned                 produced;
  int unsigned                 wr_pos;
  int unsigned                 limit;
  out_item_t                   expected_bytes[$];
  out_item_t                   batch[$];
  int                          mismatches;

  function new();
    foreach (history[i]) history[i] = '0;
    limit = pdlz_pkg::LIMIT_RESET;
    mismatches = 0;
    clear_record();
  endfunction

  function void clear_record();
    literals_left = 0;
    pair_pending = 1'b0;
    pair_high = '0;
    produced = 0;
    wr_pos = 0;
  endfunction

  function void set_limit(logic [pdlz_pkg::CNT_W-1:0] value);
    limit = value;
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  // Queue one result for this input; kept bytes enter the history and count
  function void emit(logic [pdlz_pkg::BYTE_W-1:0] data, logic bad, logic over);
    out_item_t r;
    r.data = data;
    r.last = 1'b0;
    r.bad = bad;
    r.over = over;
    batch.push_back(r);
    if (!over) begin
      history[wr_pos] = data;
      wr_pos = (wr_pos + 1) % pdlz_pkg::HISTORY_DEPTH_DEF;
      if (produced < pdlz_pkg::COUNT_MAX) produced++;
    end
  endfunction

  // Work out the results that one accepted compressed byte completes
  function void decode_input(logic [pdlz_pkg::BYTE_W-1:0] b, logic is_last);
    logic [pdlz_pkg::WORD_W-1:0] word;
    int unsigned                 copy_dist;
    int unsigned                 len;
    int unsigned                 src;
    bit                          blocked;
    blocked = produced >= limit;
    batch.delete();
    if (pair_pending) begin
      word = {pair_high, b};
      copy_dist = word >> pdlz_pkg::LENGTH_BITS_DEF;
      len = (word & ((1 << pdlz_pkg::LENGTH_BITS_DEF) - 1)) + pdlz_pkg::MIN_COPY;
      pair_pending = 1'b0;
      pair_high = '0;
      if (blocked) begin
        emit('0, 1'b0, 1'b1);
      end else if (copy_dist == 0 || copy_dist > produced ||
                   copy_dist > pdlz_pkg::HISTORY_DEPTH_DEF) begin
        repeat (len) emit('0, 1'b1, 1'b0);
      end else begin
        repeat (len) begin
          src = (wr_pos + pdlz_pkg::HISTORY_DEPTH_DEF - copy_dist) %
                pdlz_pkg::HISTORY_DEPTH_DEF;
          emit(history[src], 1'b0, 1'b0);
        end
      end
    end else if (literals_left != 0) begin
      literals_left--;
      if (blocked) emit('0, 1'b0, 1'b1);
      else emit(b, 1'b0, 1'b0);
    end else if (b >= pdlz_pkg::LIT_RUN_MIN && b <= pdlz_pkg::LIT_RUN_MAX) begin
      literals_left = b;
    end else if (b < pdlz_pkg::PAIR_BASE) begin
      if (blocked) emit('0, 1'b0, 1'b1);
      else emit(b, 1'b0, 1'b0);
    end else if (b >= pdlz_pkg::SPACE_BASE) begin
      if (blocked) begin
        emit('0, 1'b0, 1'b1);
      end else begin
        emit(pdlz_pkg::SPACE_CHAR, 1'b0, 1'b0);
        emit(b ^ pdlz_pkg::TOP_FLIP, 1'b0, 1'b0);
      end
    end else begin
      pair_pending = 1'b1;
      pair_high = b[pdlz_pkg::HIGH_W-1:0] & pdlz_pkg::HIGH_MASK;
    end
    if (is_last) begin
      if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
      clear_record();
    end
    foreach (batch[i]) expected_bytes.push_back(batch[i]);
  endfunction

  function void report(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %02h last %0b bad %0b over %0b,",
               $time, what, want.data, want.last, want.bad, want.over,
               " got byte %02h last %0b bad %0b over %0b",
               got.data, got.last, got.bad, got.over);
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_output(out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      report("unexpected result", 'x, got);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.data !== want.data || got.last !== want.last ||
        got.bad !== want.bad || got.over !== want.over)
      report("mismatch", want, got);
  endfunction
endclass

module palmdoc_lz77_decompressor_tb;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 300000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wen;
  logic [pdlz_pkg::CNT_W-1:0] cfg_wdata;

  pdlz_in_if  in_if ();
  pdlz_out_if out_if ();

  decomp_scoreboard scoreboard = new();

  int  cycles = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_served = 1'b0;
  int  hold_left = 0;
  int  rx_cycle = 0;
  int  rx_mode = 0;

  palmdoc_lz77_decompressor dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Watch both channels; inputs are noted before results of the same edge are checked
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready)
      scoreboard.decode_input(in_if.in_byte, in_if.in_last);
    if (!rst && out_if.valid && out_if.ready)
      scoreboard.check_output({out_if.out_byte, out_if.out_last,
                               out_if.bad_distance, out_if.over_limit});
  end

  // Receiver: switch stall pattern now and then, honor one long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_req && !hold_served) begin
      hold_served <= 1'b1;
      hold_left <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= (rx_cycle % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // Offer one compressed byte, with burst gaps, and hold it until accepted
  task automatic send_byte(input logic [pdlz_pkg::BYTE_W-1:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every expected result is in and the block is quiet
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [pdlz_pkg::CNT_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    scoreboard.set_limit(value);
  endtask

  // Mostly well-formed tokens with random content, some noise and early ends
  task automatic send_record(input int tokens);
    int                          est;
    int                          kind;
    int                          cnt;
    int                          copy_dist;
    logic [2:0]                  len_code;
    logic [pdlz_pkg::BYTE_W-1:0] b;
    bit                          fin;
    est = 0;
    for (int k = 0; k < tokens; k++) begin
      fin = (k == tokens - 1);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        b = 8'($urandom_range(0, 8'h7F));
        if (b >= pdlz_pkg::LIT_RUN_MIN && b <= pdlz_pkg::LIT_RUN_MAX) b = b + 8'h10;
        send_byte(b, fin);
        est += 1;
      end else if (kind < 45) begin
        send_byte(8'($urandom_range(pdlz_pkg::SPACE_BASE, 8'hFF)), fin);
        est += 2;
      end else if (kind < 55) begin
        cnt = $urandom_range(pdlz_pkg::LIT_RUN_MIN, pdlz_pkg::LIT_RUN_MAX);
        send_byte(8'(cnt), 1'b0);
        for (int i = 0; i < cnt; i++)
          send_byte(8'($urandom_range(0, 255)), fin && i == cnt - 1);
        est += cnt;
      end else if (kind < 85) begin
        len_code = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 85 && est > 0)
          copy_dist = $urandom_range(1, (est > 2047) ? 2047 : est);
        else
          copy_dist = $urandom_range(0, 2047);
        send_byte(8'(pdlz_pkg::PAIR_BASE | (copy_dist >> 5)), 1'b0);
        send_byte({copy_dist[4:0], len_code}, fin);
        est += len_code + pdlz_pkg::MIN_COPY;
      end else if (kind < 93) begin
        send_byte(8'($urandom_range(0, 255)), fin);
      end else begin
        // Cut the record inside a token
        if ($urandom_range(0, 1))
          send_byte(8'(pdlz_pkg::PAIR_BASE | $urandom_range(0, pdlz_pkg::HIGH_MASK)), 1'b1);
        else
          send_byte(8'($urandom_range(pdlz_pkg::LIT_RUN_MIN, pdlz_pkg::LIT_RUN_MAX)), 1'b1);
        return;
      end
    end
  endtask

  task automatic run_random(input int n_items, input int rec_min, input int rec_max);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_record($urandom_range(rec_min, rec_max));
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default limit: literals, spaces, copies good and bad, raw runs, early record ends
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);  // distance zero
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);  // distance one, longest copy, overlapping
    send_byte(8'h0F, 1'b0);
    send_byte(8'hBF, 1'b0);  // distance past the bytes produced
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h08, 1'b0);  // run cut short by the record end
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h81, 1'b1);  // record ends on a pending pair
    send_byte(8'h05, 1'b1);  // record ends on a count byte
    wait_idle();

    // Smallest limit: overrun on the first token, then everything dropped
    write_limit(16'd1);
    send_byte(8'hE1, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h33, 1'b1);
    wait_idle();

    // Reset limit, with a long receiver hold-off while input keeps coming
    write_limit(pdlz_pkg::LIMIT_RESET);
    run_random(8, 3, 12);
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    run_random(20, 3, 12);
    gaps_on = 1'b1;
    wait_idle();

    // Small limits so drops show up often; pause mid-phase until drained
    write_limit(16'($urandom_range(8, 40)));
    run_random(10, 4, 14);
    wait_idle();
    run_random(10, 4, 14);
    wait_idle();

    write_limit(16'd3);
    run_random(10, 2, 8);
    wait_idle();

    write_limit(16'($urandom_range(1, pdlz_pkg::LIMIT_RESET)));
    run_random(10, 3, 12);
    wait_idle();

    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
